// File: rtl/lpio_pkg.sv
// shared types and constants for the longest pairwise interval overlap block
`timescale 1ns / 1ps

package lpio_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned LEN_W   = 33;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the incoming transaction
        logic issue;   // read one stored interval into the compare pipe
        logic commit;  // store the interval or flag overflow
        logic emit;    // load the result register and clear the set
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic kept;       // captured interval has start not above end
        logic full;       // store holds the maximum number of intervals
        logic scan_done;  // every stored interval has been read
        logic pipe_busy;  // compare pipe still holds work
        logic last;       // captured transaction closes the set
        logic out_free;   // result register can take a new result
    } t_status;

endpackage

// File: rtl/lpio_datapath.sv
// datapath: interval store, compare pipeline, best overlap and result register
`timescale 1ns / 1ps

module lpio_datapath #(
    parameter int unsigned MAX_INTERVALS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lpio_pkg::t_cmd                      i_cmd,
    output lpio_pkg::t_status                   o_status,
    input  logic signed [lpio_pkg::COORD_W-1:0] i_interval_start,
    input  logic signed [lpio_pkg::COORD_W-1:0] i_interval_end,
    input  logic                                i_last_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [lpio_pkg::LEN_W-1:0]          o_overlap_length,
    output logic signed [lpio_pkg::COORD_W-1:0] o_overlap_start,
    output logic signed [lpio_pkg::COORD_W-1:0] o_overlap_end,
    output logic                                o_store_overflow
);

    localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_INTERVALS);
    localparam int unsigned CW    = lpio_pkg::COORD_W;
    localparam int unsigned LW    = lpio_pkg::LEN_W;

    // captured transaction
    logic signed [CW-1:0] r_s;
    logic signed [CW-1:0] r_e;
    logic                 r_last;
    logic                 r_kept;

    // set state
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_overflow;
    logic [LW-1:0]        r_best_len;
    logic signed [CW-1:0] r_best_start;
    logic signed [CW-1:0] r_best_end;

    // interval store
    logic [2*CW-1:0]      r_mem [MAX_INTERVALS];
    logic [2*CW-1:0]      r_rd;

    // compare pipeline
    logic                 r_p1_v;
    logic                 r_p2_v;
    logic                 r_p3_v;
    logic signed [CW-1:0] r_lo;
    logic signed [CW-1:0] r_hi;
    logic signed [CW-1:0] r_c_lo;
    logic signed [CW-1:0] r_c_hi;
    logic [LW-1:0]        r_len;

    // result register
    logic                 r_out_valid;
    logic                 r_found;
    logic [LW-1:0]        r_out_len;
    logic signed [CW-1:0] r_out_start;
    logic signed [CW-1:0] r_out_end;
    logic                 r_out_ovf;

    logic                 full;
    logic                 store_wr;
    logic signed [CW-1:0] rd_lo;
    logic signed [CW-1:0] rd_hi;
    logic signed [CW+1:0] diff;
    logic                 better;

    assign full     = (r_count == CNT_W'(MAX_INTERVALS));
    assign store_wr = i_cmd.commit && r_kept && !full;
    assign rd_lo    = $signed(r_rd[2*CW-1:CW]);
    assign rd_hi    = $signed(r_rd[CW-1:0]);
    assign diff     = {r_hi[CW-1], r_hi[CW-1], r_hi} - {r_lo[CW-1], r_lo[CW-1], r_lo}
                      + (CW+2)'(1);

    // longer wins, then smaller start, then smaller end
    assign better = (r_len > r_best_len) ||
                    ((r_len == r_best_len) &&
                     ((r_c_lo < r_best_start) ||
                      ((r_c_lo == r_best_start) && (r_c_hi < r_best_end))));

    // status to the controller
    assign o_status.kept      = r_kept;
    assign o_status.full      = full;
    assign o_status.scan_done = (r_idx == r_count);
    assign o_status.pipe_busy = r_p1_v || r_p2_v || r_p3_v;
    assign o_status.last      = r_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // capture of the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s    <= i_interval_start;
            r_e    <= i_interval_end;
            r_last <= i_last_item;
            r_kept <= (i_interval_start <= i_interval_end);
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_s, r_e};
        end
        if (i_cmd.issue) begin
            r_rd <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    // intersection bounds, then length
    always_ff @(posedge i_clk) begin
        r_lo   <= (rd_lo > r_s) ? rd_lo : r_s;
        r_hi   <= (rd_hi < r_e) ? rd_hi : r_e;
        r_c_lo <= r_lo;
        r_c_hi <= r_hi;
        r_len  <= diff[LW-1:0];
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v && (r_lo <= r_hi);
        end
    end

    // scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // set state: fill count, overflow flag, best overlap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_best_end   <= '1;
        end else begin
            if (store_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.commit && r_kept && full) begin
                r_overflow <= 1'b1;
            end
            if (r_p3_v && better) begin
                r_best_len   <= r_len;
                r_best_start <= r_c_lo;
                r_best_end   <= r_c_hi;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_found     <= (r_best_len != '0);
            r_out_len   <= r_best_len;
            r_out_start <= r_best_start;
            r_out_end   <= r_best_end;
            r_out_ovf   <= r_overflow;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_overlap_length = r_out_len;
    assign o_overlap_start  = r_out_start;
    assign o_overlap_end    = r_out_end;
    assign o_store_overflow = r_out_ovf;

endmodule

// File: rtl/lpio_ctrl.sv
// controller: sequences capture, scan, drain, commit and result
`timescale 1ns / 1ps

module lpio_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lpio_pkg::t_status i_status,
    output lpio_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   scan_more;

    assign scan_more = i_status.kept && !i_status.full && !i_status.scan_done;

    // command decode and next state
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_more) begin
                    o_cmd.issue = 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = i_status.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/longest_pairwise_interval_overlap.sv
// Longest pairwise overlap of closed intervals: top level.
// Each accepted interval is compared with every stored one (one read per cycle); the compare
//   pipe then drains and the interval is committed. An empty or full store or a reversed interval skips the reads.
// A set-closing transaction adds an emit step, which waits for the output register to be free.
// A new interval is accepted only once the previous one has been committed or emitted.
// Reset (synchronous, active low) empties the set; no store clearing pass is needed.
`timescale 1ns / 1ps

module longest_pairwise_interval_overlap #(
    parameter int unsigned MAX_INTERVALS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [lpio_pkg::COORD_W-1:0] i_interval_start,
    input  logic signed [lpio_pkg::COORD_W-1:0] i_interval_end,
    input  logic                                i_last_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [lpio_pkg::LEN_W-1:0]          o_overlap_length,
    output logic signed [lpio_pkg::COORD_W-1:0] o_overlap_start,
    output logic signed [lpio_pkg::COORD_W-1:0] o_overlap_end,
    output logic                                o_store_overflow
);

    lpio_pkg::t_cmd    cmd;
    lpio_pkg::t_status status;

    // sequencer
    lpio_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // store, compare pipe and result
    lpio_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_interval_start (i_interval_start),
        .i_interval_end   (i_interval_end),
        .i_last_item      (i_last_item),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_overlap_length (o_overlap_length),
        .o_overlap_start  (o_overlap_start),
        .o_overlap_end    (o_overlap_end),
        .o_store_overflow (o_store_overflow)
    );

    // an accepted transaction keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transaction");

    // reads are issued only for a kept interval with room in the store
    a_issue_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> (status.kept && !status.full && !status.scan_done))
        else $error("store read issued outside a valid scan");

    // emitting a result fills the output register
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out_valid)
        else $error("emitted result not presented");

    // an empty result carries the fixed bounds
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
            (o_overlap_length == '0 && o_overlap_start == '0 && o_overlap_end == '1))
        else $error("empty result with wrong bounds");

    // a found overlap has nonzero length
    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_overlap_length != '0))
        else $error("found overlap with zero length");

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the longest pairwise interval overlap block
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned STORE_DEPTH = 256;
    localparam int unsigned ITEM_TARGET = 950;
    localparam int unsigned HOLD_CYCLES = 600;

    localparam logic signed [lpio_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [lpio_pkg::COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

    // interval generation modes
    localparam int GEN_ANY      = 0;
    localparam int GEN_KEPT     = 1;
    localparam int GEN_REVERSED = 2;

    typedef struct packed {
        logic                                found;
        logic [lpio_pkg::LEN_W-1:0]          length;
        logic signed [lpio_pkg::COORD_W-1:0] lo;
        logic signed [lpio_pkg::COORD_W-1:0] hi;
        logic                                overflow;
    } t_overlap;

    typedef struct packed {
        logic signed [lpio_pkg::COORD_W-1:0] start;
        logic signed [lpio_pkg::COORD_W-1:0] stop;
        logic                                last;
        logic                                typed;
        t_overlap                            want;
    } t_stim_row;

    localparam t_overlap NO_OVERLAP = '{1'b0, 33'd0, 32'sd0, -32'sd1, 1'b0};
    localparam int DIR_ROWS = 19;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic signed [lpio_pkg::COORD_W-1:0] i_interval_start = '0;
    logic signed [lpio_pkg::COORD_W-1:0] i_interval_end = '0;
    logic                                i_last_item = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic                                o_found;
    logic [lpio_pkg::LEN_W-1:0]          o_overlap_length;
    logic signed [lpio_pkg::COORD_W-1:0] o_overlap_start;
    logic signed [lpio_pkg::COORD_W-1:0] o_overlap_end;
    logic                                o_store_overflow;

    // predictor state: stored intervals and best overlap of the open set
    longint      span_lo [STORE_DEPTH];
    longint      span_hi [STORE_DEPTH];
    int unsigned span_count = 0;
    longint      best_len = 0;
    longint      best_lo = 0;
    longint      best_hi = -1;
    bit          saw_overflow = 1'b0;

    t_overlap    pending_overlaps[$];
    t_stim_row   dir_table [DIR_ROWS];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int          burst_left = 0;
    int          rx_cycle = 0;
    int          hold_left = 0;
    int          hold_requests = 0;
    int          hold_served = 0;

    longest_pairwise_interval_overlap #(
        .MAX_INTERVALS(STORE_DEPTH)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_interval_start (i_interval_start),
        .i_interval_end   (i_interval_end),
        .i_last_item      (i_last_item),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_overlap_length (o_overlap_length),
        .o_overlap_start  (o_overlap_start),
        .o_overlap_end    (o_overlap_end),
        .o_store_overflow (o_store_overflow)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // fold one accepted interval into the predicted set, close the set on last
    task automatic track_overlap(input logic signed [lpio_pkg::COORD_W-1:0] s,
                                 input logic signed [lpio_pkg::COORD_W-1:0] e,
                                 input bit last, output bit emits, output t_overlap res);
        longint ls;
        longint le;
        longint lo;
        longint hi;
        longint len;
        ls = s;
        le = e;
        emits = 1'b0;
        res = NO_OVERLAP;
        if (ls <= le) begin
            if (span_count < STORE_DEPTH) begin
                for (int i = 0; i < span_count; i++) begin
                    lo = (span_lo[i] > ls) ? span_lo[i] : ls;
                    hi = (span_hi[i] < le) ? span_hi[i] : le;
                    if (lo <= hi) begin
                        len = hi - lo + 1;
                        if (len > best_len || (len == best_len &&
                            (lo < best_lo || (lo == best_lo && hi < best_hi)))) begin
                            best_len = len;
                            best_lo = lo;
                            best_hi = hi;
                        end
                    end
                end
                span_lo[span_count] = ls;
                span_hi[span_count] = le;
                span_count++;
            end else begin
                saw_overflow = 1'b1;
            end
        end
        if (last) begin
            emits = 1'b1;
            if (best_len > 0) begin
                res.found = 1'b1;
                res.length = best_len[lpio_pkg::LEN_W-1:0];
                res.lo = best_lo[lpio_pkg::COORD_W-1:0];
                res.hi = best_hi[lpio_pkg::COORD_W-1:0];
            end
            res.overflow = saw_overflow;
            span_count = 0;
            best_len = 0;
            best_lo = 0;
            best_hi = -1;
            saw_overflow = 1'b0;
        end
    endtask

    // offer one transaction, with bursty idling unless asked to stream
    task automatic send_interval(input logic signed [lpio_pkg::COORD_W-1:0] s,
                                 input logic signed [lpio_pkg::COORD_W-1:0] e,
                                 input bit last, input bit typed, input t_overlap typed_want,
                                 input bit stream);
        bit       emits;
        t_overlap res;
        int       gap;
        if (!stream) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 15);
                burst_left = $urandom_range(1, 24);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_interval_start <= s;
        i_interval_end <= e;
        i_last_item <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_overlap(s, e, last, emits, res);
        if (emits) pending_overlaps.push_back(typed ? typed_want : res);
        items_sent++;
    endtask

    // coordinates: mostly small so overlaps are common, plus extremes and full range
    function automatic logic signed [lpio_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9)) inside
            [0:4]:   return $urandom_range(0, 80) - 40;
            [5:6]:   return $urandom();
            7:       return COORD_MIN + $urandom_range(0, 20);
            8:       return COORD_MAX - $urandom_range(0, 20);
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    task automatic send_random(input int mode, input bit last, input bit stream);
        logic signed [lpio_pkg::COORD_W-1:0] a;
        logic signed [lpio_pkg::COORD_W-1:0] b;
        logic signed [lpio_pkg::COORD_W-1:0] t;
        a = pick_coord();
        b = pick_coord();
        if (mode == GEN_KEPT || (mode == GEN_ANY && $urandom_range(0, 9) != 0)) begin
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
        end else if (mode == GEN_REVERSED) begin
            if (a < b) begin
                t = a;
                a = b;
                b = t;
            end
            if (a == b) begin
                if (a == COORD_MIN) a = a + 1;
                else b = b - 1;
            end
        end
        send_interval(a, b, last, 1'b0, NO_OVERLAP, stream);
    endtask

    task automatic run_set(input int n, input bit stream);
        for (int i = 0; i < n; i++) send_random(GEN_ANY, i == n - 1, stream);
    endtask

    // drop valid and hold the sender until every pending result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_overlaps.size() != 0);
    endtask

    // receiver: rotating stall patterns, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 250) % 4)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (rx_cycle % 7 == 0);
            endcase
        end
        rx_cycle++;
    end

    // compare each delivered result with the oldest pending one
    always @(posedge i_clk) begin : check_results
        t_overlap want;
        t_overlap got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_found, o_overlap_length, o_overlap_start, o_overlap_end,
                    o_store_overflow};
            if (pending_overlaps.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: found=%0b len=%0d lo=%0d hi=%0d ovf=%0b",
                             got.found, got.length, got.lo, got.hi, got.overflow);
                mismatches++;
            end else begin
                want = pending_overlaps.pop_front();
                if (got.found !== want.found || got.length !== want.length ||
                    got.lo !== want.lo || got.hi !== want.hi ||
                    got.overflow !== want.overflow) begin
                    if (mismatches < 10) begin
                        $display("mismatch exp: found=%0b len=%0d lo=%0d hi=%0d ovf=%0b",
                                 want.found, want.length, want.lo, want.hi, want.overflow);
                        $display("         act: found=%0b len=%0d lo=%0d hi=%0d ovf=%0b",
                                 got.found, got.length, got.lo, got.hi, got.overflow);
                    end
                    mismatches++;
                end
            end
        end
    end

    // directed rows: typed results for the obvious cases, predictor elsewhere
    initial begin
        // single interval, then a reversed one closing its own set
        dir_table[0]  = '{32'sd0, 32'sd0, 1'b1, 1'b1, NO_OVERLAP};
        dir_table[1]  = '{32'sd5, 32'sd3, 1'b1, 1'b1, NO_OVERLAP};
        // full coordinate range twice
        dir_table[2]  = '{COORD_MIN, COORD_MAX, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[3]  = '{COORD_MIN, COORD_MAX, 1'b1, 1'b1,
                          '{1'b1, 33'h1_0000_0000, COORD_MIN, COORD_MAX, 1'b0}};
        // single points at the top and bottom
        dir_table[4]  = '{COORD_MAX, COORD_MAX, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[5]  = '{COORD_MAX, COORD_MAX, 1'b1, 1'b1,
                          '{1'b1, 33'd1, COORD_MAX, COORD_MAX, 1'b0}};
        dir_table[6]  = '{COORD_MIN, COORD_MIN, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[7]  = '{COORD_MIN, COORD_MIN, 1'b1, 1'b1,
                          '{1'b1, 33'd1, COORD_MIN, COORD_MIN, 1'b0}};
        // equal lengths, smaller start wins
        dir_table[8]  = '{32'sd0, 32'sd9, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[9]  = '{32'sd5, 32'sd14, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[10] = '{-32'sd5, 32'sd4, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[11] = '{32'sd20, 32'sd30, 1'b1, 1'b0, NO_OVERLAP};
        // reversed interval in the middle of a set is dropped
        dir_table[12] = '{32'sd0, 32'sd10, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[13] = '{32'sd10, 32'sd0, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[14] = '{32'sd3, 32'sd7, 1'b1, 1'b0, NO_OVERLAP};
        // adjacent intervals do not overlap
        dir_table[15] = '{32'sd0, 32'sd4, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[16] = '{32'sd5, 32'sd9, 1'b1, 1'b1, NO_OVERLAP};
        // touching intervals share one point
        dir_table[17] = '{32'sd0, 32'sd5, 1'b0, 1'b0, NO_OVERLAP};
        dir_table[18] = '{32'sd5, 32'sd9, 1'b1, 1'b0, NO_OVERLAP};
    end

    // main stimulus
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_interval(dir_table[r].start, dir_table[r].stop, dir_table[r].last,
                          dir_table[r].typed, dir_table[r].want, 1'b0);
        wait_drained();

        // receiver holds off while short sets stream in and back up the block
        hold_requests++;
        for (int k = 0; k < 8; k++) run_set($urandom_range(1, 2), 1'b1);

        // store full: a reversed one and kept ones past the limit, last one overflows
        for (int i = 0; i < STORE_DEPTH; i++) send_random(GEN_KEPT, 1'b0, 1'b0);
        send_random(GEN_REVERSED, 1'b0, 1'b0);
        for (int i = 0; i < 3; i++) send_random(GEN_KEPT, 1'b0, 1'b0);
        send_random(GEN_KEPT, 1'b1, 1'b0);

        // store filled exactly, no overflow
        for (int i = 0; i < STORE_DEPTH; i++)
            send_random(GEN_KEPT, i == STORE_DEPTH - 1, $urandom_range(0, 1));

        // random sets, mostly short, some longer, some streamed
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) run_set($urandom_range(20, 40), 1'b0);
            else run_set($urandom_range(1, 8), $urandom_range(0, 3) == 0);
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && pending_overlaps.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #25ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lpio_pkg.sv
rtl/lpio_datapath.sv
rtl/lpio_ctrl.sv
rtl/longest_pairwise_interval_overlap.sv
tb/sv/testbench.sv
